### design/ata_pio_command_issuer_macros.svh
// Assertion macros for the ATA PIO command issuer
`ifndef ATA_PIO_COMMAND_ISSUER_MACROS_SVH
`define ATA_PIO_COMMAND_ISSUER_MACROS_SVH
`ifndef SYNTHESIS
`define ATA_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ata pio assertion failed");
`define ATA_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ata pio assertion failed");
`else
`define ATA_ASSERT_IMP(name, clk, rstn, ante, cons)
`define ATA_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

### design/ata_pio_pkg.sv
// Shared types and constants for the ATA PIO command issuer
`timescale 1ns / 1ps
package ata_pio_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int OFFSET_W     = 57;
    localparam int COUNT_W      = 32;
    localparam int CAP_W        = 48;
    localparam int SUM_W        = OFFSET_W + 1;
    localparam int END_W        = SUM_W - SECTOR_SHIFT;
    localparam int NSEC_LO_W    = 33 - SECTOR_SHIFT;
    localparam int ROOM_W       = 34;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 48;
    localparam int NUM_DRIVES   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY3   = 3'd4;

    localparam logic [8:0] PRI_BASE   = 9'h1f0;
    localparam logic [8:0] SEC_BASE   = 9'h170;
    localparam logic [7:0] DEV_LBA    = 8'he0;
    localparam logic [7:0] DEV_SLAVE  = 8'hb0;
    localparam logic [7:0] DEV_MASTER = 8'ha0;
    localparam logic [7:0] CMD_READ28  = 8'h20;
    localparam logic [7:0] CMD_READ48  = 8'h24;
    localparam logic [7:0] CMD_WRITE28 = 8'h30;
    localparam logic [7:0] CMD_WRITE48 = 8'h34;
    localparam logic [7:0] NIBBLE     = 8'h0f;

    localparam logic [2:0] PORT_SECCOUNT = 3'd2;
    localparam logic [2:0] PORT_LBA_LO   = 3'd3;
    localparam logic [2:0] PORT_LBA_MID  = 3'd4;
    localparam logic [2:0] PORT_LBA_HI   = 3'd5;
    localparam logic [2:0] PORT_DEVICE   = 3'd6;
    localparam logic [2:0] PORT_COMMAND  = 3'd7;

    localparam logic [3:0] LAST_BEAT28 = 4'd5;
    localparam logic [3:0] LAST_BEAT48 = 4'd9;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_CHS   = 2'd1,
        MODE_LBA28 = 2'd2,
        MODE_LBA48 = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NOTHING  = 2'd2
    } status_t;

    typedef struct packed {
        logic                action;
        logic [2:0]          drive;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  byte_count;
    } req_t;

    typedef struct packed {
        logic [8:0]         port_address;
        logic [7:0]         port_value;
        logic               last;
        logic [1:0]         status;
        logic [COUNT_W-1:0] transfer_bytes;
    } rsp_t;

    typedef struct packed {
        logic [7:0]                       drive_modes;
        logic [NUM_DRIVES-1:0][CAP_W-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic               lba48;
        logic               action;
        logic               secondary;
        logic               slave;
        logic [CAP_W-1:0]   start;
        logic [15:0]        nsec;
        logic [COUNT_W-1:0] xfer;
    } plan_t;

endpackage

### design/ata_pio_cfg_regs.sv
// Configuration registers: drive modes and per-drive capacities
`timescale 1ns / 1ps
module ata_pio_cfg_regs
    import ata_pio_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DRIVE_MODES: cfg_next.drive_modes = cfg_data[7:0];
                CFG_CAPACITY0:   cfg_next.capacity[0] = cfg_data[CAP_W-1:0];
                CFG_CAPACITY1:   cfg_next.capacity[1] = cfg_data[CAP_W-1:0];
                CFG_CAPACITY2:   cfg_next.capacity[2] = cfg_data[CAP_W-1:0];
                CFG_CAPACITY3:   cfg_next.capacity[3] = cfg_data[CAP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/ata_pio_range.sv
// Request pipeline: sector range, clamp to capacity, transfer size and status
`timescale 1ns / 1ps
module ata_pio_range
    import ata_pio_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  plan_valid,
    input  logic  plan_ready,
    output plan_t plan
);

    typedef struct packed {
        logic                    action;
        logic [1:0]              drive;
        logic                    bad;
        logic                    beyond;
        mode_t                   mode;
        logic [CAP_W-1:0]        start;
        logic [END_W-1:0]        end_sec;
        logic [CAP_W-1:0]        cap;
        logic [SECTOR_SHIFT-1:0] inner;
        logic [COUNT_W-1:0]      count;
    } s1_t;

    typedef struct packed {
        logic                    action;
        logic [1:0]              drive;
        logic                    bad;
        logic                    beyond;
        mode_t                   mode;
        logic [CAP_W-1:0]        start;
        logic [CAP_W-1:0]        nsec;
        logic [SECTOR_SHIFT-1:0] inner;
        logic [COUNT_W-1:0]      count;
    } s2_t;

    logic  s0_valid_reg, s1_valid_reg, s2_valid_reg;
    req_t  s0_reg;
    s1_t   s1_reg, s1_next;
    s2_t   s2_reg, s2_next;
    logic  ready0, ready1, ready2;

    logic [SUM_W-1:0]   sum;
    logic [CAP_W-1:0]   cap_sel;
    logic               end_gt_cap;
    logic [ROOM_W-1:0]  room;
    logic               big;
    logic [COUNT_W-1:0] xfer;
    status_t            status;

    assign ready2    = !s2_valid_reg || plan_ready;
    assign ready1    = !s1_valid_reg || ready2;
    assign ready0    = !s0_valid_reg || ready1;
    assign req_ready = ready0;

    // stage one: start sector, rounded-up end sector, capacity lookup
    always_comb
    begin
        cap_sel = cfg.capacity[s0_reg.drive[1:0]];
        sum = SUM_W'(s0_reg.byte_offset) + SUM_W'(s0_reg.byte_count)
            + SUM_W'(SECTOR_BYTES - 1);
        s1_next.action  = s0_reg.action;
        s1_next.drive   = s0_reg.drive[1:0];
        s1_next.bad     = s0_reg.drive[2];
        s1_next.start   = CAP_W'(s0_reg.byte_offset[OFFSET_W-1:SECTOR_SHIFT]);
        s1_next.beyond  = s1_next.start >= cap_sel;
        s1_next.mode    = mode_t'(cfg.drive_modes[{s0_reg.drive[1:0], 1'b0} +: 2]);
        s1_next.end_sec = sum[SUM_W-1:SECTOR_SHIFT];
        s1_next.cap     = cap_sel;
        s1_next.inner   = s0_reg.byte_offset[SECTOR_SHIFT-1:0];
        s1_next.count   = s0_reg.byte_count;
    end

    // stage two: clamp the end and take the sector count
    always_comb
    begin
        end_gt_cap     = s1_reg.end_sec > END_W'(s1_reg.cap);
        s2_next.action = s1_reg.action;
        s2_next.drive  = s1_reg.drive;
        s2_next.bad    = s1_reg.bad;
        s2_next.beyond = s1_reg.beyond;
        s2_next.mode   = s1_reg.mode;
        s2_next.start  = s1_reg.start;
        s2_next.nsec   = end_gt_cap ? (s1_reg.cap - s1_reg.start)
                                    : (s1_reg.end_sec[CAP_W-1:0] - s1_reg.start);
        s2_next.inner  = s1_reg.inner;
        s2_next.count  = s1_reg.count;
    end

    // stage three: bytes moved and final status
    always_comb
    begin
        big  = |s2_reg.nsec[CAP_W-1:NSEC_LO_W];
        room = ROOM_W'({s2_reg.nsec[NSEC_LO_W-1:0], {SECTOR_SHIFT{1'b0}}})
             - ROOM_W'(s2_reg.inner);
        xfer = (big || (ROOM_W'(s2_reg.count) <= room)) ? s2_reg.count
                                                        : room[COUNT_W-1:0];
        if (s2_reg.bad)
            status = ST_BAD;
        else if (s2_reg.beyond || (s2_reg.nsec == '0))
            status = ST_NOTHING;
        else if (s2_reg.mode != MODE_LBA28 && s2_reg.mode != MODE_LBA48)
            status = ST_BAD;
        else
            status = ST_OK;

        plan.status    = status;
        plan.lba48     = s2_reg.mode == MODE_LBA48;
        plan.action    = s2_reg.action;
        plan.secondary = s2_reg.drive[1];
        plan.slave     = s2_reg.drive[0];
        plan.start     = s2_reg.start;
        plan.nsec      = s2_reg.nsec[15:0];
        plan.xfer      = xfer;
    end

    assign plan_valid = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
                s0_valid_reg <= req_valid;
            if (ready1)
                s1_valid_reg <= s0_valid_reg;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready0)
            s0_reg <= req;
        if (ready1)
            s1_reg <= s1_next;
        if (ready2)
            s2_reg <= s2_next;
    end

endmodule

### design/ata_pio_emit.sv
// Beat sequencer: walks the task-file writes of one command into the output register
`timescale 1ns / 1ps
`include "ata_pio_command_issuer_macros.svh"
module ata_pio_emit
    import ata_pio_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  plan_valid,
    output logic  plan_ready,
    input  plan_t plan,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

    function automatic rsp_t make_beat(plan_t p, logic [3:0] idx);
        rsp_t       b;
        logic [2:0] off;
        logic [7:0] val;
        logic [8:0] base;
        logic [7:0] dev;
        logic       lst;
        base = p.secondary ? SEC_BASE : PRI_BASE;
        dev  = p.slave ? DEV_SLAVE : DEV_MASTER;
        off  = PORT_COMMAND;
        val  = '0;
        lst  = 1'b0;
        if (p.lba48)
        begin
            case (idx)
                4'd0:    begin off = PORT_SECCOUNT; val = p.nsec[15:8];   end
                4'd1:    begin off = PORT_LBA_LO;   val = p.start[31:24]; end
                4'd2:    begin off = PORT_LBA_MID;  val = p.start[39:32]; end
                4'd3:    begin off = PORT_LBA_HI;   val = p.start[47:40]; end
                4'd4:    begin off = PORT_SECCOUNT; val = p.nsec[7:0];    end
                4'd5:    begin off = PORT_LBA_LO;   val = p.start[7:0];   end
                4'd6:    begin off = PORT_LBA_MID;  val = p.start[15:8];  end
                4'd7:    begin off = PORT_LBA_HI;   val = p.start[23:16]; end
                4'd8:    begin off = PORT_DEVICE;   val = DEV_LBA | dev;  end
                default:
                begin
                    off = PORT_COMMAND;
                    val = p.action ? CMD_WRITE48 : CMD_READ48;
                    lst = 1'b1;
                end
            endcase
        end
        else
        begin
            case (idx)
                4'd0:    begin off = PORT_SECCOUNT; val = p.nsec[7:0];    end
                4'd1:    begin off = PORT_LBA_LO;   val = p.start[7:0];   end
                4'd2:    begin off = PORT_LBA_MID;  val = p.start[15:8];  end
                4'd3:    begin off = PORT_LBA_HI;   val = p.start[23:16]; end
                4'd4:
                begin
                    off = PORT_DEVICE;
                    val = ({4'b0, p.start[27:24]} & NIBBLE) | DEV_LBA | dev;
                end
                default:
                begin
                    off = PORT_COMMAND;
                    val = p.action ? CMD_WRITE28 : CMD_READ28;
                    lst = 1'b1;
                end
            endcase
        end
        if (p.status != ST_OK)
        begin
            b.port_address   = '0;
            b.port_value     = '0;
            b.last           = 1'b1;
            b.status         = p.status;
            b.transfer_bytes = '0;
        end
        else
        begin
            b.port_address   = base + {6'b0, off};
            b.port_value     = val;
            b.last           = lst;
            b.status         = ST_OK;
            b.transfer_bytes = p.xfer;
        end
        return b;
    endfunction

    plan_t      plan_reg;
    logic       plan_valid_reg;
    logic [3:0] idx_reg;
    rsp_t       rsp_reg;
    logic       rsp_valid_reg;
    rsp_t       beat;
    logic       out_free;
    logic       push;
    logic       load;

    assign beat       = make_beat(plan_reg, idx_reg);
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign push       = plan_valid_reg && out_free;
    assign plan_ready = !plan_valid_reg || (out_free && beat.last);
    assign load       = plan_valid && plan_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (push)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            if (load)
            begin
                plan_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (push)
            begin
                if (beat.last)
                    plan_valid_reg <= 1'b0;
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan;
        if (push)
            rsp_reg <= beat;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ATA_ASSERT_IMP(a_idx_lba48, clk, rst_n, plan_valid_reg, idx_reg <= LAST_BEAT48)
    `ATA_ASSERT_IMP(a_idx_lba28, clk, rst_n, plan_valid_reg && !plan_reg.lba48, idx_reg <= LAST_BEAT28)
    `ATA_ASSERT_IMP(a_status_single, clk, rst_n, rsp_valid_reg && rsp_reg.status != ST_OK, rsp_reg.last && rsp_reg.port_address == '0 && rsp_reg.transfer_bytes == '0)
    `ATA_ASSERT_NXT(a_load_restart, clk, rst_n, load, plan_valid_reg && idx_reg == '0)

endmodule

### design/ata_pio_command_issuer.sv
// ATA PIO command issuer: turns a byte request into LBA28/LBA48 task-file writes.
// Request path: range registers s0, s1, s2, then the plan and output registers.
// Throughput: one beat per cycle at the output register unless rsp_ready stalls it;
// a request is 6 beats (LBA28), 10 (LBA48) or 1 (status only) via that single register.
// Reset: asynchronous, active low; clears all configuration to zero and empties the pipe.
`timescale 1ns / 1ps
module ata_pio_command_issuer
    import ata_pio_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    cfg_t  cfg;
    plan_t plan;
    logic  plan_valid;
    logic  plan_ready;

    ata_pio_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ata_pio_range u_range (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .plan_valid (plan_valid),
        .plan_ready (plan_ready),
        .plan       (plan)
    );

    ata_pio_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (plan_valid),
        .plan_ready (plan_ready),
        .plan       (plan),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

### verif/ata_pio_command_issuer_tb.sv
// Self-checking testbench for the ATA PIO command issuer: directed table, then random requests
`timescale 1ns / 1ps
module ata_pio_command_issuer_tb;
    import ata_pio_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PER_SETTING   = 45;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_CAPACITY3 + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    typedef enum logic {
        STEP_CFG,
        STEP_REQ
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        req_t                  r;
        logic                  typed;
        status_t               status;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp;

    logic [7:0]       modes_reg = '0;
    logic [CAP_W-1:0] cap_model [NUM_DRIVES] = '{default: '0};
    rsp_t             pending_writes [$];
    step_t            dir_steps [$];
    int unsigned      send_idle_pct = 0;
    int unsigned      stall_pct = 0;
    int unsigned      mismatches = 0;
    int               cycle_count = 0;

    ata_pio_command_issuer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("ata_pio_command_issuer_tb: done, errors");
            $finish;
        end
    end

    function automatic void push_beat(input logic [8:0] addr, input logic [7:0] value,
                                      input logic last, input status_t st,
                                      input logic [COUNT_W-1:0] xfer);
        rsp_t e;
        e.port_address   = addr;
        e.port_value     = value;
        e.last           = last;
        e.status         = st;
        e.transfer_bytes = xfer;
        pending_writes.push_back(e);
    endfunction

    function automatic void predict_task_file(input req_t r);
        logic [63:0] cap, start, stop, nsec, inner, room, xfer;
        mode_t       mode;
        logic [8:0]  base;
        logic [7:0]  dev;
        logic [31:0] xb;
        if (r.drive >= NUM_DRIVES)
        begin
            push_beat('0, '0, 1'b1, ST_BAD, '0);
            return;
        end
        cap   = 64'(cap_model[r.drive[1:0]]);
        start = 64'(r.byte_offset) >> SECTOR_SHIFT;
        if (start >= cap)
        begin
            push_beat('0, '0, 1'b1, ST_NOTHING, '0);
            return;
        end
        stop = (64'(r.byte_offset) + 64'(r.byte_count) + 64'(SECTOR_BYTES - 1)) >> SECTOR_SHIFT;
        if (stop > cap)
            stop = cap;
        nsec = stop - start;
        if (nsec == 0)
        begin
            push_beat('0, '0, 1'b1, ST_NOTHING, '0);
            return;
        end
        mode = mode_t'(modes_reg[2 * r.drive[1:0] +: 2]);
        if (mode == MODE_NONE || mode == MODE_CHS)
        begin
            push_beat('0, '0, 1'b1, ST_BAD, '0);
            return;
        end
        inner = 64'(r.byte_offset) & 64'(SECTOR_BYTES - 1);
        room  = (nsec << SECTOR_SHIFT) - inner;
        xfer  = (64'(r.byte_count) > room) ? room : 64'(r.byte_count);
        xb    = xfer[31:0];
        base  = (r.drive < 2) ? PRI_BASE : SEC_BASE;
        dev   = r.drive[0] ? DEV_SLAVE : DEV_MASTER;
        if (mode == MODE_LBA28)
        begin
            push_beat(base + 9'(PORT_SECCOUNT), nsec[7:0], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_LO), start[7:0], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_MID), start[15:8], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_HI), start[23:16], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_DEVICE), (start[31:24] & NIBBLE) | DEV_LBA | dev,
                      1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_COMMAND), r.action ? CMD_WRITE28 : CMD_READ28,
                      1'b1, ST_OK, xb);
        end
        else
        begin
            push_beat(base + 9'(PORT_SECCOUNT), nsec[15:8], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_LO), start[31:24], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_MID), start[39:32], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_HI), start[47:40], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_SECCOUNT), nsec[7:0], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_LO), start[7:0], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_MID), start[15:8], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_LBA_HI), start[23:16], 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_DEVICE), DEV_LBA | dev, 1'b0, ST_OK, xb);
            push_beat(base + 9'(PORT_COMMAND), r.action ? CMD_WRITE48 : CMD_READ48,
                      1'b1, ST_OK, xb);
        end
    endfunction

    function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s       = '0;
        s.kind  = STEP_CFG;
        s.index = idx;
        s.data  = data;
        return s;
    endfunction

    function automatic step_t req_step(input logic a, input logic [2:0] d,
                                       input logic [OFFSET_W-1:0] off,
                                       input logic [COUNT_W-1:0] cnt,
                                       input logic typed, input status_t st);
        step_t s;
        s                = '0;
        s.kind           = STEP_REQ;
        s.r.action       = a;
        s.r.drive        = d;
        s.r.byte_offset  = off;
        s.r.byte_count   = cnt;
        s.typed          = typed;
        s.status         = st;
        return s;
    endfunction

    function automatic logic [CAP_W-1:0] random_capacity();
        logic [63:0] pick;
        int unsigned roll;
        pick = {$urandom, $urandom};
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return '1;
        if (roll < 40)
            return CAP_W'($urandom_range(64, 1));
        if (roll < 60)
            return CAP_W'(64'h0fff_ffe0 + 64'($urandom_range(64)));
        return pick[CAP_W-1:0];
    endfunction

    function automatic req_t random_request();
        req_t        r;
        logic [63:0] cap, start, pick;
        int unsigned roll;
        r.action = 1'($urandom_range(1));
        r.drive  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
        cap      = 64'(cap_model[r.drive[1:0]]);
        pick     = {$urandom, $urandom};
        roll     = $urandom_range(99);
        if (roll < 15 || cap == 0)
            r.byte_offset = pick[OFFSET_W-1:0];
        else
        begin
            if (roll < 55)
                start = cap - 1 - (pick % ((cap < 24) ? cap : 64'd24));
            else if (roll < 70 && cap > 64'h1000_0000)
                start = 64'h0fff_fff0 + (pick % 32);
            else
                start = pick % cap;
            r.byte_offset = OFFSET_W'((start << SECTOR_SHIFT)
                                      | 64'($urandom_range(SECTOR_BYTES - 1)));
        end
        roll = $urandom_range(99);
        if (roll < 10)
            r.byte_count = '0;
        else if (roll < 20)
            r.byte_count = '1;
        else if (roll < 65)
            r.byte_count = COUNT_W'($urandom_range(8192));
        else
            r.byte_count = $urandom;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_DRIVE_MODES)
            modes_reg = data[7:0];
        else if (idx >= CFG_CAPACITY0 && idx <= CFG_CAPACITY3)
            cap_model[2'(idx - CFG_CAPACITY0)] = data[CAP_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic put_request(input req_t r, input logic typed, input status_t st);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
        if (typed)
            push_beat('0, '0, 1'b1, st, '0);
        else
            predict_task_file(r);
    endtask

    // drop valid and wait for every outstanding beat, then let the pipe empty
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected beat: port_address %0h port_value %0h",
                       rsp.port_address, rsp.port_value);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (rsp.port_address !== want.port_address)
                begin
                    $error("port_address: expected %0h, got %0h",
                           want.port_address, rsp.port_address);
                    mismatches++;
                end
                if (rsp.port_value !== want.port_value)
                begin
                    $error("port_value: expected %0h, got %0h", want.port_value, rsp.port_value);
                    mismatches++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, rsp.last);
                    mismatches++;
                end
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatches++;
                end
                if (rsp.transfer_bytes !== want.transfer_bytes)
                begin
                    $error("transfer_bytes: expected %0d, got %0d",
                           want.transfer_bytes, rsp.transfer_bytes);
                    mismatches++;
                end
            end
        end
        rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        logic [7:0] modes;
        int         k;
        dir_steps = '{
            req_step(1'b0, 3'd0, '0, 32'd512, 1'b1, ST_NOTHING),
            req_step(1'b1, 3'd7, '1, '1, 1'b1, ST_BAD),
            req_step(1'b0, 3'd4, '0, '0, 1'b1, ST_BAD),
            cfg_step(CFG_DRIVE_MODES, 48'hbe),
            cfg_step(CFG_CAPACITY0, 48'h1000_0010),
            cfg_step(CFG_CAPACITY1, '1),
            cfg_step(CFG_CAPACITY2, 48'd1000),
            cfg_step(CFG_CAPACITY3, 48'd1),
            cfg_step(CFG_SPARE_LO, 48'h123),
            cfg_step(CFG_SPARE_HI, '1),
            req_step(1'b0, 3'd0, '0, 32'd1, 1'b0, ST_OK),
            req_step(1'b1, 3'd0, 57'h1f_ffff_e003, 32'd4096, 1'b0, ST_OK),
            req_step(1'b0, 3'd0, 57'h20_0000_1000, '1, 1'b0, ST_OK),
            req_step(1'b0, 3'd0, '0, '0, 1'b1, ST_NOTHING),
            req_step(1'b1, 3'd0, 57'd100, '0, 1'b0, ST_OK),
            req_step(1'b0, 3'd1, '1, '1, 1'b1, ST_NOTHING),
            req_step(1'b0, 3'd1, 57'h1ff_ffff_ffff_fc00, '1, 1'b0, ST_OK),
            req_step(1'b1, 3'd1, '0, '1, 1'b0, ST_OK),
            req_step(1'b0, 3'd2, 57'd511488, 32'd1024, 1'b0, ST_OK),
            req_step(1'b1, 3'd2, 57'd512000, 32'd1, 1'b1, ST_NOTHING),
            req_step(1'b0, 3'd3, '0, '1, 1'b0, ST_OK),
            req_step(1'b1, 3'd3, 57'd511, 32'd2, 1'b0, ST_OK),
            req_step(1'b1, 3'd5, '0, 32'd512, 1'b1, ST_BAD),
            req_step(1'b0, 3'd6, '0, '0, 1'b1, ST_BAD),
            cfg_step(CFG_DRIVE_MODES, 48'h44),
            req_step(1'b0, 3'd0, '0, 32'd512, 1'b1, ST_BAD),
            req_step(1'b1, 3'd1, '0, 32'd512, 1'b1, ST_BAD),
            req_step(1'b0, 3'd2, '0, '0, 1'b1, ST_NOTHING),
            req_step(1'b1, 3'd3, '0, 32'd1, 1'b1, ST_BAD)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_CFG)
            begin
                settle();
                write_reg(dir_steps[i].index, dir_steps[i].data);
            end
            else
                put_request(dir_steps[i].r, dir_steps[i].typed, dir_steps[i].status);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 75 : (ph == 3) ? 33 : 0;
            stall_pct     = (ph == 2) ? 75 : (ph == 3) ? 33 : 0;
            for (int s = 0; s < 2; s++)
            begin
                k = ph * 2 + s;
                settle();
                modes = (k == 0) ? 8'hff : (k == 1) ? 8'haa : 8'($urandom);
                write_reg(CFG_DRIVE_MODES, CFG_DATA_W'(modes));
                if (k == 0)
                begin
                    write_reg(CFG_CAPACITY0, '1);
                    write_reg(CFG_CAPACITY1, 48'd1);
                    write_reg(CFG_CAPACITY2, 48'h1000_0008);
                    write_reg(CFG_CAPACITY3, random_capacity());
                end
                else
                    for (int d = 0; d < NUM_DRIVES; d++)
                        write_reg(CFG_IDX_W'(CFG_CAPACITY0 + d), random_capacity());
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
                          CFG_DATA_W'({$urandom, $urandom}));
                repeat (PER_SETTING) put_request(random_request(), 1'b0, ST_OK);
            end
        end

        settle();
        if (mismatches == 0)
            $display("ata_pio_command_issuer_tb: done, clean");
        else
            $display("ata_pio_command_issuer_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/ata_pio_pkg.sv
design/ata_pio_cfg_regs.sv
design/ata_pio_range.sv
design/ata_pio_emit.sv
design/ata_pio_command_issuer.sv
verif/ata_pio_command_issuer_tb.sv
